// ----- src/rcd_pkg.sv -----
// rcd_pkg: widths, register indexes and small helpers for the RSA CRT decrypt block.
// Used by rcd_div, rcd_mul and rsa_crt_decrypt; depends on nothing.
package rcd_pkg;

    localparam int PW        = 16;  // prime, residue and exponent-residue width
    localparam int WW        = 32;  // ciphertext, modulus and plaintext width
    localparam int DVW       = 33;  // dividend width of the shared divider
    localparam int MW        = 18;  // signed multiplier operand width
    localparam int DIV_STEPS = 33;  // one quotient bit per cycle
    localparam int DCW       = 6;   // divider step counter width

    localparam logic [1:0] CFG_EXP = 2'd0;
    localparam logic [1:0] CFG_P   = 2'd1;
    localparam logic [1:0] CFG_Q   = 2'd2;
    localparam logic [1:0] CFG_N   = 2'd3;

    typedef logic signed [MW-1:0]   mop_t;
    typedef logic signed [2*MW-1:0] prod_t;

    typedef struct packed {
        logic go;
    } div_ctl_t;

    typedef struct packed {
        logic done;
    } div_sts_t;

    function automatic mop_t to_mop(input logic [PW-1:0] v);
        return $signed({2'b00, v});
    endfunction

endpackage

// ----- src/rcd_div.sv -----
// rcd_div: restoring divider, one quotient bit per cycle, shared by every reduction.
// Depends on rcd_pkg.
module rcd_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  rcd_pkg::div_ctl_t           ctl,
    input  logic [rcd_pkg::DVW-1:0]     dividend,
    input  logic [rcd_pkg::WW-1:0]      divisor,
    output rcd_pkg::div_sts_t           sts,
    output logic [rcd_pkg::DVW-1:0]     quotient,
    output logic [rcd_pkg::WW-1:0]      remainder
);

    logic                       run_reg, run_next;
    logic                       done_reg, done_next;
    logic [rcd_pkg::DCW-1:0]    cnt_reg, cnt_next;
    logic [rcd_pkg::WW-1:0]     rem_reg, rem_next;
    logic [rcd_pkg::DVW-1:0]    quo_reg, quo_next;
    logic [rcd_pkg::WW-1:0]     dvs_reg, dvs_next;
    logic [rcd_pkg::DVW-1:0]    trial;
    logic [rcd_pkg::DVW-1:0]    diff;
    logic                       ge;

    assign trial = {rem_reg, quo_reg[rcd_pkg::DVW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (ctl.go)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[rcd_pkg::WW-1:0] : trial[rcd_pkg::WW-1:0];
            quo_next = {quo_reg[rcd_pkg::DVW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rcd_pkg::DCW'(rcd_pkg::DIV_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign sts.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- src/rcd_mul.sv -----
// rcd_mul: registered signed 18x18 multiplier shared by Euclid, exponentiation and Garner.
// Depends on rcd_pkg.
module rcd_mul
(
    input  logic            clk,
    input  rcd_pkg::mop_t   a,
    input  rcd_pkg::mop_t   b,
    output rcd_pkg::prod_t  prod
);

    rcd_pkg::prod_t prod_reg, prod_next;

    assign prod_next = a * b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ----- src/rsa_crt_decrypt.sv -----
// rsa_crt_decrypt: top level, key registers and the sequencer that drives the shared units.
// Depends on rcd_pkg, rcd_div and rcd_mul.
//
//  channel  | ports                                  | transfer when
//  ---------+----------------------------------------+--------------------------
//  input    | start, cipher_value                    | start high and busy low
//  result   | done, plain_value, key_error           | done high (one cycle)
//  config   | cfg_we, cfg_index, cfg_data            | cfg_we high
//
// One item runs through extended Euclid (q^-1 mod p), two reductions of d,
// two square-and-multiply exponentiations and Garner recombination. Every
// modular reduction goes through the one restoring divider and every multiply
// through the one registered multiplier. The work for an item grows with E the
// Euclid steps, Bp and Bq the bit lengths of dP and dQ and W their set bits.
// busy stays high for the whole item, except that a key error found at start
// (p zero and q not one) is reported with busy low; the result strobe cannot
// be stalled.
// Reset clears the sequencer and loads the key registers with d=0, p=2, q=3, n=6.
module rsa_crt_decrypt
#(
    parameter int PRIME_BITS = 16,
    parameter int EXP_BITS   = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [31:0]             cipher_value,
    output logic                    done,
    output logic [31:0]             plain_value,
    output logic                    key_error,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [31:0]             cfg_data
);

    localparam int PB = (PRIME_BITS < rcd_pkg::PW) ? PRIME_BITS : rcd_pkg::PW;
    localparam int EB = (EXP_BITS < rcd_pkg::WW) ? EXP_BITS : rcd_pkg::WW;
    localparam logic [rcd_pkg::PW-1:0] PMASK =
        rcd_pkg::PW'(((rcd_pkg::PW+1)'(1) << PB) - (rcd_pkg::PW+1)'(1));
    localparam logic [rcd_pkg::WW-1:0] DMASK =
        rcd_pkg::WW'(((rcd_pkg::WW+1)'(1) << EB) - (rcd_pkg::WW+1)'(1));

    typedef enum logic [28:0] {
        S_IDLE   = 29'h1 << 0,
        S_EINIT  = 29'h1 << 1,
        S_ELOOP  = 29'h1 << 2,
        S_EDIV   = 29'h1 << 3,
        S_EMUL   = 29'h1 << 4,
        S_EUPD   = 29'h1 << 5,
        S_DP     = 29'h1 << 6,
        S_DPW    = 29'h1 << 7,
        S_DQ     = 29'h1 << 8,
        S_DQW    = 29'h1 << 9,
        S_PINIT  = 29'h1 << 10,
        S_PBASE  = 29'h1 << 11,
        S_PLOOP  = 29'h1 << 12,
        S_PAM    = 29'h1 << 13,
        S_PAD    = 29'h1 << 14,
        S_PAW    = 29'h1 << 15,
        S_PBM    = 29'h1 << 16,
        S_PBD    = 29'h1 << 17,
        S_PBW    = 29'h1 << 18,
        S_PDONE  = 29'h1 << 19,
        S_GSTART = 29'h1 << 20,
        S_G1W    = 29'h1 << 21,
        S_G2W    = 29'h1 << 22,
        S_G2M    = 29'h1 << 23,
        S_G3     = 29'h1 << 24,
        S_G3W    = 29'h1 << 25,
        S_G4M    = 29'h1 << 26,
        S_G5     = 29'h1 << 27,
        S_G5W    = 29'h1 << 28
    } state_t;

    state_t state_reg, state_next;

    // key registers
    logic [31:0]                exp_reg, exp_next;
    logic [15:0]                prime_p_reg, prime_p_next;
    logic [15:0]                prime_q_reg, prime_q_next;
    logic [31:0]                modulus_reg, modulus_next;

    // working registers
    logic [rcd_pkg::WW-1:0]     c_reg, c_next;
    logic [rcd_pkg::PW-1:0]     r0_reg, r0_next, r1_reg, r1_next;
    rcd_pkg::mop_t              t0_reg, t0_next, t1_reg, t1_next;
    logic [rcd_pkg::PW-1:0]     qinv_reg, qinv_next;
    logic [rcd_pkg::PW-1:0]     dp_reg, dp_next, dq_reg, dq_next;
    logic [rcd_pkg::PW-1:0]     mp_reg, mp_next, mq_reg, mq_next;
    logic [rcd_pkg::PW-1:0]     acc_reg, acc_next, b_reg, b_next, e_reg, e_next;
    logic                       sel_reg, sel_next;

    // shared unit operands
    logic                       div_go_reg, div_go_next;
    logic [rcd_pkg::DVW-1:0]    div_a_reg, div_a_next;
    logic [rcd_pkg::WW-1:0]     div_b_reg, div_b_next;
    rcd_pkg::mop_t              mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;

    // result registers
    logic                       done_reg, done_next;
    logic [rcd_pkg::WW-1:0]     plain_reg, plain_next;
    logic                       kerr_reg, kerr_next;

    rcd_pkg::div_ctl_t          div_ctl;
    rcd_pkg::div_sts_t          div_sts;
    logic [rcd_pkg::DVW-1:0]    div_quo;
    logic [rcd_pkg::WW-1:0]     div_rem;
    rcd_pkg::prod_t             mul_prod;

    logic [rcd_pkg::PW-1:0]     p_eff, q_eff, m_cur;
    logic [rcd_pkg::WW-1:0]     d_eff;
    logic [rcd_pkg::PW-1:0]     rem16;
    rcd_pkg::prod_t             t_new;
    rcd_pkg::mop_t              t_wrap;
    logic [rcd_pkg::PW:0]       gdiff;
    logic [rcd_pkg::DVW-1:0]    m_sum;

    assign p_eff  = prime_p_reg & PMASK;
    assign q_eff  = prime_q_reg & PMASK;
    assign d_eff  = exp_reg & DMASK;
    assign m_cur  = sel_reg ? q_eff : p_eff;
    assign rem16  = div_rem[rcd_pkg::PW-1:0];
    assign t_new  = rcd_pkg::prod_t'(t0_reg) - mul_prod;
    assign t_wrap = t0_reg + rcd_pkg::to_mop(p_eff);
    assign gdiff  = {1'b0, mp_reg} + {1'b0, p_eff} - {1'b0, rem16};
    assign m_sum  = rcd_pkg::DVW'(mq_reg) + mul_prod[rcd_pkg::DVW-1:0];

    assign div_ctl.go = div_go_reg;

    rcd_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_a_reg),
        .divisor   (div_b_reg),
        .sts       (div_sts),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    rcd_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a_reg),
        .b    (mul_b_reg),
        .prod (mul_prod)
    );

    // key register writes
    always_comb
    begin
        exp_next     = exp_reg;
        prime_p_next = prime_p_reg;
        prime_q_next = prime_q_reg;
        modulus_next = modulus_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rcd_pkg::CFG_EXP: exp_next     = cfg_data;
                rcd_pkg::CFG_P:   prime_p_next = cfg_data[15:0];
                rcd_pkg::CFG_Q:   prime_q_next = cfg_data[15:0];
                rcd_pkg::CFG_N:   modulus_next = cfg_data;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        c_next      = c_reg;
        r0_next     = r0_reg;
        r1_next     = r1_reg;
        t0_next     = t0_reg;
        t1_next     = t1_reg;
        qinv_next   = qinv_reg;
        dp_next     = dp_reg;
        dq_next     = dq_reg;
        mp_next     = mp_reg;
        mq_next     = mq_reg;
        acc_next    = acc_reg;
        b_next      = b_reg;
        e_next      = e_reg;
        sel_next    = sel_reg;
        div_go_next = 1'b0;
        div_a_next  = div_a_reg;
        div_b_next  = div_b_reg;
        mul_a_next  = mul_a_reg;
        mul_b_next  = mul_b_reg;
        done_next   = 1'b0;
        plain_next  = plain_reg;
        kerr_next   = kerr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    c_next = cipher_value;
                    if (p_eff == '0)
                    begin
                        // inverse mod zero exists only for q equal to one
                        qinv_next = '0;
                        if (q_eff == rcd_pkg::PW'(1))
                            state_next = S_DP;
                        else
                        begin
                            plain_next = '0;
                            kerr_next  = 1'b1;
                            done_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        div_go_next = 1'b1;
                        div_a_next  = rcd_pkg::DVW'(q_eff);
                        div_b_next  = rcd_pkg::WW'(p_eff);
                        state_next  = S_EINIT;
                    end
                end
            end
            S_EINIT:
            begin
                if (div_sts.done)
                begin
                    r0_next    = p_eff;
                    r1_next    = rem16;
                    t0_next    = '0;
                    t1_next    = rcd_pkg::mop_t'(1);
                    state_next = S_ELOOP;
                end
            end
            S_ELOOP:
            begin
                if (r1_reg == '0)
                begin
                    if (r0_reg != rcd_pkg::PW'(1))
                    begin
                        plain_next = '0;
                        kerr_next  = 1'b1;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        qinv_next  = t0_reg[rcd_pkg::MW-1] ? t_wrap[rcd_pkg::PW-1:0]
                                                           : t0_reg[rcd_pkg::PW-1:0];
                        state_next = S_DP;
                    end
                end
                else
                begin
                    div_go_next = 1'b1;
                    div_a_next  = rcd_pkg::DVW'(r0_reg);
                    div_b_next  = rcd_pkg::WW'(r1_reg);
                    state_next  = S_EDIV;
                end
            end
            S_EDIV:
            begin
                if (div_sts.done)
                begin
                    mul_a_next = rcd_pkg::to_mop(div_quo[rcd_pkg::PW-1:0]);
                    mul_b_next = t1_reg;
                    r0_next    = r1_reg;
                    r1_next    = rem16;
                    state_next = S_EMUL;
                end
            end
            S_EMUL:
            begin
                state_next = S_EUPD;
            end
            S_EUPD:
            begin
                t0_next    = t1_reg;
                t1_next    = t_new[rcd_pkg::MW-1:0];
                state_next = S_ELOOP;
            end
            S_DP:
            begin
                if (p_eff >= rcd_pkg::PW'(2))
                begin
                    div_go_next = 1'b1;
                    div_a_next  = rcd_pkg::DVW'(d_eff);
                    div_b_next  = rcd_pkg::WW'(p_eff - 1'b1);
                    state_next  = S_DPW;
                end
                else
                begin
                    dp_next    = '0;
                    state_next = S_DQ;
                end
            end
            S_DPW:
            begin
                if (div_sts.done)
                begin
                    dp_next    = rem16;
                    state_next = S_DQ;
                end
            end
            S_DQ:
            begin
                if (q_eff >= rcd_pkg::PW'(2))
                begin
                    div_go_next = 1'b1;
                    div_a_next  = rcd_pkg::DVW'(d_eff);
                    div_b_next  = rcd_pkg::WW'(q_eff - 1'b1);
                    state_next  = S_DQW;
                end
                else
                begin
                    dq_next    = '0;
                    sel_next   = 1'b0;
                    state_next = S_PINIT;
                end
            end
            S_DQW:
            begin
                if (div_sts.done)
                begin
                    dq_next    = rem16;
                    sel_next   = 1'b0;
                    state_next = S_PINIT;
                end
            end
            S_PINIT:
            begin
                if (m_cur < rcd_pkg::PW'(2))
                begin
                    acc_next   = '0;
                    state_next = S_PDONE;
                end
                else
                begin
                    div_go_next = 1'b1;
                    div_a_next  = rcd_pkg::DVW'(c_reg);
                    div_b_next  = rcd_pkg::WW'(m_cur);
                    state_next  = S_PBASE;
                end
            end
            S_PBASE:
            begin
                if (div_sts.done)
                begin
                    b_next     = rem16;
                    acc_next   = rcd_pkg::PW'(1);
                    e_next     = sel_reg ? dq_reg : dp_reg;
                    state_next = S_PLOOP;
                end
            end
            S_PLOOP:
            begin
                if (e_reg == '0)
                    state_next = S_PDONE;
                else if (e_reg[0])
                begin
                    mul_a_next = rcd_pkg::to_mop(acc_reg);
                    mul_b_next = rcd_pkg::to_mop(b_reg);
                    state_next = S_PAM;
                end
                else
                begin
                    mul_a_next = rcd_pkg::to_mop(b_reg);
                    mul_b_next = rcd_pkg::to_mop(b_reg);
                    state_next = S_PBM;
                end
            end
            S_PAM:
            begin
                state_next = S_PAD;
            end
            S_PAD:
            begin
                div_go_next = 1'b1;
                div_a_next  = mul_prod[rcd_pkg::DVW-1:0];
                div_b_next  = rcd_pkg::WW'(m_cur);
                state_next  = S_PAW;
            end
            S_PAW:
            begin
                if (div_sts.done)
                begin
                    acc_next   = rem16;
                    mul_a_next = rcd_pkg::to_mop(b_reg);
                    mul_b_next = rcd_pkg::to_mop(b_reg);
                    state_next = S_PBM;
                end
            end
            S_PBM:
            begin
                state_next = S_PBD;
            end
            S_PBD:
            begin
                div_go_next = 1'b1;
                div_a_next  = mul_prod[rcd_pkg::DVW-1:0];
                div_b_next  = rcd_pkg::WW'(m_cur);
                state_next  = S_PBW;
            end
            S_PBW:
            begin
                if (div_sts.done)
                begin
                    b_next     = rem16;
                    e_next     = e_reg >> 1;
                    state_next = S_PLOOP;
                end
            end
            S_PDONE:
            begin
                if (!sel_reg)
                begin
                    mp_next    = acc_reg;
                    sel_next   = 1'b1;
                    state_next = S_PINIT;
                end
                else
                begin
                    mq_next    = acc_reg;
                    state_next = S_GSTART;
                end
            end
            S_GSTART:
            begin
                if (p_eff == '0)
                begin
                    // h is zero: multiply zero by q to keep one recombine path
                    mul_a_next = '0;
                    mul_b_next = rcd_pkg::to_mop(q_eff);
                    state_next = S_G4M;
                end
                else
                begin
                    div_go_next = 1'b1;
                    div_a_next  = rcd_pkg::DVW'(mq_reg);
                    div_b_next  = rcd_pkg::WW'(p_eff);
                    state_next  = S_G1W;
                end
            end
            S_G1W:
            begin
                if (div_sts.done)
                begin
                    div_go_next = 1'b1;
                    div_a_next  = rcd_pkg::DVW'(gdiff);
                    div_b_next  = rcd_pkg::WW'(p_eff);
                    state_next  = S_G2W;
                end
            end
            S_G2W:
            begin
                if (div_sts.done)
                begin
                    mul_a_next = rcd_pkg::to_mop(qinv_reg);
                    mul_b_next = rcd_pkg::to_mop(rem16);
                    state_next = S_G2M;
                end
            end
            S_G2M:
            begin
                state_next = S_G3;
            end
            S_G3:
            begin
                div_go_next = 1'b1;
                div_a_next  = mul_prod[rcd_pkg::DVW-1:0];
                div_b_next  = rcd_pkg::WW'(p_eff);
                state_next  = S_G3W;
            end
            S_G3W:
            begin
                if (div_sts.done)
                begin
                    mul_a_next = rcd_pkg::to_mop(rem16);
                    mul_b_next = rcd_pkg::to_mop(q_eff);
                    state_next = S_G4M;
                end
            end
            S_G4M:
            begin
                state_next = S_G5;
            end
            S_G5:
            begin
                if (modulus_reg == '0)
                begin
                    plain_next = '0;
                    kerr_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    div_go_next = 1'b1;
                    div_a_next  = m_sum;
                    div_b_next  = modulus_reg;
                    state_next  = S_G5W;
                end
            end
            S_G5W:
            begin
                if (div_sts.done)
                begin
                    plain_next = div_rem;
                    kerr_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_go_reg  <= 1'b0;
            done_reg    <= 1'b0;
            exp_reg     <= 32'd0;
            prime_p_reg <= 16'd2;
            prime_q_reg <= 16'd3;
            modulus_reg <= 32'd6;
        end
        else
        begin
            state_reg   <= state_next;
            div_go_reg  <= div_go_next;
            done_reg    <= done_next;
            exp_reg     <= exp_next;
            prime_p_reg <= prime_p_next;
            prime_q_reg <= prime_q_next;
            modulus_reg <= modulus_next;
        end
    end

    // hold working values; no reset needed
    always_ff @(posedge clk)
    begin
        c_reg     <= c_next;
        r0_reg    <= r0_next;
        r1_reg    <= r1_next;
        t0_reg    <= t0_next;
        t1_reg    <= t1_next;
        qinv_reg  <= qinv_next;
        dp_reg    <= dp_next;
        dq_reg    <= dq_next;
        mp_reg    <= mp_next;
        mq_reg    <= mq_next;
        acc_reg   <= acc_next;
        b_reg     <= b_next;
        e_reg     <= e_next;
        sel_reg   <= sel_next;
        div_a_reg <= div_a_next;
        div_b_reg <= div_b_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        plain_reg <= plain_next;
        kerr_reg  <= kerr_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign plain_value = plain_reg;
    assign key_error   = kerr_reg;

endmodule

// ----- src/rcd_checker.sv -----
// rcd_checker: port-level assertions for rsa_crt_decrypt, bound to the top level.
// Depends on the rsa_crt_decrypt port list only.
module rcd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] plain_value,
    input logic        key_error
);

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !done |=> busy || done)
        else $error("accepted item did not start work");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("work ended without a result");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && key_error |-> plain_value == 32'd0)
        else $error("key error with nonzero plaintext");

endmodule

bind rsa_crt_decrypt rcd_checker u_rcd_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .plain_value (plain_value),
    .key_error   (key_error)
);
